// ===== rtl/i2c_register_master_unit_assert.svh =====
// Assertion macros shared by the I2C register master RTL.
`ifndef I2C_REGISTER_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_MASTER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante; quiet while reset is held.
`define I2CRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante; quiet while reset is held.
`define I2CRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2crm_pkg.sv =====
// Shared types and constants of the I2C register master.
package i2crm_pkg;

  localparam int unsigned HalfW    = 10;
  localparam int unsigned StretchW = 8;
  localparam int unsigned CfgW     = 10;

  // Register indexes of the configuration port.
  localparam logic CfgHalfPeriod   = 1'b0;
  localparam logic CfgStretchLimit = 1'b1;

  // Input mode codes.
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  // One classified tick as it travels from the front to the engine.
  typedef struct packed {
    logic       cmd_start;
    logic       cmd_read;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       scl;
    logic       sda;
  } tick_t;

  // One result beat.
  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       busy;
    logic       done;
    logic       status;
    logic       arb_lost;
  } res_t;

endpackage

// ===== rtl/i2crm_front.sv =====
// Front end: accepts tick beats, decodes the mode and queues them for the engine.
`include "i2c_register_master_unit_assert.svh"
module i2crm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [6:0]        device_addr_i,
  input  logic [7:0]        reg_addr_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        read_count_i,
  input  logic              scl_in_i,
  input  logic              sda_in_i,
  output logic              q_valid_o,
  output i2crm_pkg::tick_t  q_item_o,
  input  logic              q_pop_i
);
  import i2crm_pkg::*;

  tick_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push;
  tick_t      item;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  // Mode three falls back to a plain tick.
  always_comb begin
    item.cmd_start   = (mode_i == ModeWrite) || (mode_i == ModeRead);
    item.cmd_read    = (mode_i == ModeRead);
    item.device_addr = device_addr_i;
    item.reg_addr    = reg_addr_i;
    item.write_data  = write_data_i;
    item.read_count  = read_count_i;
    item.scl         = scl_in_i;
    item.sda         = sda_in_i;
  end

  always_comb begin
    count_d = count_q;
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= item;
  end

  `I2CRM_ASSERT_NOW(a_count_range, 1'b1, count_q <= 2'd2, "queue count out of range")
  `I2CRM_ASSERT_NOW(a_pop_nonempty, q_pop_i, count_q != 2'd0, "pop from empty queue")

endmodule

// ===== rtl/i2crm_engine.sv =====
// Back end: the bus sequencer that steps once per queued tick, plus the result register.
`include "i2c_register_master_unit_assert.svh"
module i2crm_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [i2crm_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                       q_valid_i,
  input  i2crm_pkg::tick_t           q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output i2crm_pkg::res_t            res_o
);
  import i2crm_pkg::*;

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhStartA = 4'd1;
  localparam logic [3:0] PhStartB = 4'd2;
  localparam logic [3:0] PhSetup  = 4'd3;
  localparam logic [3:0] PhRise   = 4'd4;
  localparam logic [3:0] PhHigh   = 4'd5;
  localparam logic [3:0] PhStopA  = 4'd6;
  localparam logic [3:0] PhStopB  = 4'd7;
  localparam logic [3:0] PhStopC  = 4'd8;
  localparam logic [3:0] PhStopD  = 4'd9;

  localparam logic [2:0] SgAddrW  = 3'd0;
  localparam logic [2:0] SgReg    = 3'd1;
  localparam logic [2:0] SgData   = 3'd2;
  localparam logic [2:0] SgAddrR  = 3'd3;
  localparam logic [2:0] SgRead   = 3'd4;
  localparam logic [2:0] SgFinal  = 3'd5;
  localparam logic [2:0] SgReStop = 3'd6;

  logic [HalfW-1:0]    cfg_half_q;
  logic [StretchW-1:0] cfg_stretch_q;

  logic [3:0]          phase_q, phase_d;
  logic [2:0]          stage_q, stage_d;
  logic [3:0]          bit_idx_q, bit_idx_d;
  logic [7:0]          bytes_left_q, bytes_left_d;
  logic [7:0]          shift_q, shift_d;
  logic [HalfW-1:0]    half_tmr_q, half_tmr_d;
  logic [StretchW-1:0] str_tmr_q, str_tmr_d;
  logic [6:0]          held_dev_q, held_dev_d;
  logic [7:0]          held_reg_q, held_reg_d;
  logic [7:0]          held_data_q, held_data_d;
  logic                is_read_q, is_read_d;
  logic                failed_q, failed_d;

  logic                out_valid_q;
  res_t                res_q, res_d;

  logic                pop;
  logic [HalfW-1:0]    hp, ht_inc;
  logic                hold_fin, rise_fin, sending, s;
  logic [7:0]          bl_dec;

  // Drive-low level of SDA for the current bit slot.
  function automatic logic bit_low(input logic [3:0] idx, input logic [2:0] sg,
                                   input logic [7:0] sh, input logic [7:0] bl);
    logic r;
    if (!idx[3]) begin
      r = (sg == SgRead) ? 1'b0 : !sh[~idx[2:0]];
    end else begin
      r = (sg == SgRead) ? (bl > 8'd1) : 1'b0;
    end
    return r;
  endfunction

  assign pop         = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign hp       = (cfg_half_q == '0) ? HalfW'(1) : cfg_half_q;
  assign ht_inc   = half_tmr_q + HalfW'(1);
  assign hold_fin = (ht_inc >= hp);
  assign rise_fin = q_item_i.scl || (str_tmr_q >= cfg_stretch_q);
  assign s        = q_item_i.sda;
  assign sending  = (stage_q == SgRead) ? bit_idx_q[3] : !bit_idx_q[3];
  assign bl_dec   = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : bytes_left_q;

  always_comb begin
    phase_d      = phase_q;
    stage_d      = stage_q;
    bit_idx_d    = bit_idx_q;
    bytes_left_d = bytes_left_q;
    shift_d      = shift_q;
    half_tmr_d   = half_tmr_q;
    str_tmr_d    = str_tmr_q;
    held_dev_d   = held_dev_q;
    held_reg_d   = held_reg_q;
    held_data_d  = held_data_q;
    is_read_d    = is_read_q;
    failed_d     = failed_q;
    res_d        = '0;

    case (phase_q)
      PhIdle: begin
        if (q_item_i.cmd_start) begin
          held_dev_d   = q_item_i.device_addr;
          held_reg_d   = q_item_i.reg_addr;
          held_data_d  = q_item_i.write_data;
          bytes_left_d = q_item_i.read_count;
          is_read_d    = q_item_i.cmd_read;
          failed_d     = 1'b0;
          bit_idx_d    = 4'd0;
          stage_d      = SgAddrW;
          shift_d      = {q_item_i.device_addr, 1'b0};
          phase_d      = PhStartA;
          half_tmr_d   = '0;
          str_tmr_d    = '0;
        end
      end
      PhStartA, PhStartB, PhSetup, PhStopA, PhStopC: begin
        half_tmr_d = ht_inc;
        if (hold_fin) begin
          half_tmr_d = '0;
          str_tmr_d  = '0;
          case (phase_q)
            PhStartA: begin
              res_d.arb_lost = !s;
              phase_d        = PhStartB;
            end
            PhStartB: begin
              bit_idx_d = 4'd0;
              phase_d   = PhSetup;
            end
            PhSetup: phase_d = PhRise;
            PhStopA: phase_d = PhStopB;
            default: phase_d = PhStopD;
          endcase
        end
      end
      PhRise, PhStopB: begin
        if (rise_fin) begin
          phase_d    = (phase_q == PhRise) ? PhHigh : PhStopC;
          half_tmr_d = '0;
          str_tmr_d  = '0;
        end else begin
          str_tmr_d = str_tmr_q + StretchW'(1);
        end
      end
      PhHigh: begin
        half_tmr_d = ht_inc;
        if (hold_fin) begin
          half_tmr_d = '0;
          str_tmr_d  = '0;
          res_d.arb_lost = sending && !bit_low(bit_idx_q, stage_q, shift_q, bytes_left_q)
                           && !s;
          phase_d = PhSetup;
          if (!bit_idx_q[3]) begin
            if (stage_q == SgRead) shift_d = {shift_q[6:0], s};
            bit_idx_d = bit_idx_q + 4'd1;
          end else begin
            bit_idx_d = 4'd0;
            case (stage_q)
              SgRead: begin
                res_d.byte_valid = 1'b1;
                res_d.read_byte  = shift_q;
                res_d.last_byte  = (bytes_left_q == 8'd1);
                bytes_left_d     = bl_dec;
                if (bl_dec == 8'd0) begin
                  stage_d = SgFinal;
                  phase_d = PhStopA;
                end else begin
                  shift_d = 8'd0;
                end
              end
              SgAddrW: begin
                if (s) begin
                  failed_d = 1'b1;
                  stage_d  = SgFinal;
                  phase_d  = PhStopA;
                end else begin
                  stage_d = SgReg;
                  shift_d = held_reg_q;
                end
              end
              SgReg: begin
                if (is_read_q) begin
                  stage_d = SgReStop;
                  phase_d = PhStopA;
                end else if (s) begin
                  failed_d = 1'b1;
                  stage_d  = SgFinal;
                  phase_d  = PhStopA;
                end else begin
                  stage_d = SgData;
                  shift_d = held_data_q;
                end
              end
              SgData: begin
                failed_d = s;
                stage_d  = SgFinal;
                phase_d  = PhStopA;
              end
              SgAddrR: begin
                if (s) begin
                  failed_d = 1'b1;
                  stage_d  = SgFinal;
                  phase_d  = PhStopA;
                end else if (bytes_left_q == 8'd0) begin
                  stage_d = SgFinal;
                  phase_d = PhStopA;
                end else begin
                  stage_d = SgRead;
                  shift_d = 8'd0;
                end
              end
              default: begin
                stage_d = SgFinal;
                phase_d = PhStopA;
              end
            endcase
          end
        end
      end
      PhStopD: begin
        half_tmr_d = ht_inc;
        if (hold_fin) begin
          half_tmr_d     = '0;
          str_tmr_d      = '0;
          res_d.arb_lost = !s;
          if (stage_q == SgReStop) begin
            stage_d   = SgAddrR;
            shift_d   = {held_dev_q, 1'b1};
            bit_idx_d = 4'd0;
            phase_d   = PhStartA;
          end else begin
            phase_d    = PhIdle;
            res_d.done = 1'b1;
          end
        end
      end
      default: begin
        phase_d    = PhIdle;
        half_tmr_d = '0;
        str_tmr_d  = '0;
      end
    endcase

    // Line drive for the coming tick follows the phase just entered.
    case (phase_d)
      PhStartB: res_d.sda_low = 1'b1;
      PhSetup: begin
        res_d.scl_low = 1'b1;
        res_d.sda_low = bit_low(bit_idx_d, stage_d, shift_d, bytes_left_d);
      end
      PhRise, PhHigh: res_d.sda_low = bit_low(bit_idx_d, stage_d, shift_d, bytes_left_d);
      PhStopA: begin
        res_d.scl_low = 1'b1;
        res_d.sda_low = 1'b1;
      end
      PhStopB, PhStopC: res_d.sda_low = 1'b1;
      default: res_d.sda_low = 1'b0;
    endcase

    res_d.busy   = (phase_d != PhIdle);
    res_d.status = res_d.done && failed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_half_q    <= HalfW'(1);
      cfg_stretch_q <= StretchW'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHalfPeriod:   cfg_half_q    <= cfg_wdata_i[HalfW-1:0];
        CfgStretchLimit: cfg_stretch_q <= cfg_wdata_i[StretchW-1:0];
        default:         cfg_half_q    <= cfg_half_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      stage_q      <= SgAddrW;
      bit_idx_q    <= 4'd0;
      bytes_left_q <= 8'd0;
      shift_q      <= 8'd0;
      half_tmr_q   <= '0;
      str_tmr_q    <= '0;
      held_dev_q   <= 7'd0;
      held_reg_q   <= 8'd0;
      held_data_q  <= 8'd0;
      is_read_q    <= 1'b0;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        phase_q      <= phase_d;
        stage_q      <= stage_d;
        bit_idx_q    <= bit_idx_d;
        bytes_left_q <= bytes_left_d;
        shift_q      <= shift_d;
        half_tmr_q   <= half_tmr_d;
        str_tmr_q    <= str_tmr_d;
        held_dev_q   <= held_dev_d;
        held_reg_q   <= held_reg_d;
        held_data_q  <= held_data_d;
        is_read_q    <= is_read_d;
        failed_q     <= failed_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) res_q <= res_d;
  end

  `I2CRM_ASSERT_NOW(a_done_not_busy, out_valid_q && res_q.done, !res_q.busy,
                    "done beat while still busy")
  `I2CRM_ASSERT_NOW(a_last_has_byte, out_valid_q && res_q.last_byte, res_q.byte_valid,
                    "last_byte without byte_valid")
  `I2CRM_ASSERT_NOW(a_idle_timer_clear, phase_q == PhIdle, half_tmr_q == '0,
                    "half timer running while idle")
  `I2CRM_ASSERT_NOW(a_bit_index_range, 1'b1, bit_idx_q <= 4'd8, "bit index past ACK slot")

endmodule

// ===== rtl/i2c_register_master_unit.sv =====
// Top level of the I2C register master: tick front end, bus engine and port mapping.
// The block is an open-drain I2C master that advances by one bus tick per input
// beat: each beat carries the sampled SCL and SDA levels and optionally a new
// register-write (mode 1) or register-read (mode 2) command, and each beat yields
// exactly one result beat with the line drive for the next tick, a received byte
// when one completes (with its last-of-run flag), busy, a done pulse with status
// (0 success, 1 no acknowledge) and an arbitration-loss pulse. Throughput is one
// tick per clock cycle while the output is not stalled: the engine step is pure
// combinational logic, and a two-entry queue plus an output register keep input
// and output stalls apart; results are registered as ticks leave the queue.
// Commands given while a command is in progress are ignored; mode 3 is a plain
// tick. Configuration register 0 sets ticks per half SCL period (0 acts as 1,
// reset 1) and register 1 sets the SCL stretch wait limit (reset 10); write them
// only while no tick is in flight.
module i2c_register_master_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [i2crm_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [6:0]                 device_addr_i,
  input  logic [7:0]                 reg_addr_i,
  input  logic [7:0]                 write_data_i,
  input  logic [7:0]                 read_count_i,
  input  logic                       scl_in_i,
  input  logic                       sda_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       scl_low_o,
  output logic                       sda_low_o,
  output logic                       byte_valid_o,
  output logic [7:0]                 read_byte_o,
  output logic                       last_byte_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic                       status_o,
  output logic                       arb_lost_o
);
  import i2crm_pkg::*;

  logic  q_valid, q_pop;
  tick_t q_item;
  res_t  res;

  // Accept and decode tick beats; hold up to two for the engine.
  i2crm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .device_addr_i,
    .reg_addr_i,
    .write_data_i,
    .read_count_i,
    .scl_in_i,
    .sda_in_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Step the bus sequencer once per queued tick and register its result beat.
  i2crm_engine u_engine (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_stall_i,
    .res_o       (res)
  );

  // Spread the result beat over its ports.
  assign scl_low_o    = res.scl_low;
  assign sda_low_o    = res.sda_low;
  assign byte_valid_o = res.byte_valid;
  assign read_byte_o  = res.read_byte;
  assign last_byte_o  = res.last_byte;
  assign busy_res_o   = res.busy;
  assign done_res_o   = res.done;
  assign status_o     = res.status;
  assign arb_lost_o   = res.arb_lost;

endmodule
